@@ rtl/hmd_pkg.sv @@
package hmd_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int POS_W = 17;
  localparam int REM_W = 16;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [CFG_INDEX_W-1:0] CFG_ID_MIN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ID_MAX = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIG_MAX = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_CH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_SH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_CA = 3'd5;

  localparam logic [7:0] RST_ID_MIN = 8'd1;
  localparam logic [7:0] RST_ID_MAX = 8'd64;
  localparam logic [15:0] RST_SIG_MAX = 16'd4627;
  localparam logic [7:0] RST_CODE_CH = 8'd1;
  localparam logic [7:0] RST_CODE_SH = 8'd2;
  localparam logic [7:0] RST_CODE_CA = 8'd3;

  localparam logic [1:0] KIND_CLIENT_HELLO = 2'd0;
  localparam logic [1:0] KIND_SERVER_HELLO = 2'd1;
  localparam logic [1:0] KIND_CLIENT_AUTH = 2'd2;

  typedef enum logic [3:0] {
    FLD_TYPE = 4'd0,
    FLD_IDLEN = 4'd1,
    FLD_ID = 4'd2,
    FLD_PUBKEY = 4'd3,
    FLD_SESSION = 4'd4,
    FLD_NONCE = 4'd5,
    FLD_HSID = 4'd6,
    FLD_SIGLEN = 4'd7,
    FLD_SIG = 4'd8,
    FLD_END = 4'd9
  } field_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_TYPE = 3'd1,
    ERR_ID_LEN = 3'd2,
    ERR_SIG_LEN = 3'd3,
    ERR_SHORT = 3'd4,
    ERR_TRAILING = 3'd5
  } err_t;

  typedef struct packed {
    logic [7:0] id_min_length;
    logic [7:0] id_max_length;
    logic [15:0] sig_max_length;
    logic [7:0] code_client_hello;
    logic [7:0] code_server_hello;
    logic [7:0] code_client_auth;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic last_byte;
    logic [1:0] expected_kind;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [3:0] field_code;
    logic [POS_W-1:0] byte_offset;
    logic msg_done;
    logic msg_valid;
    logic [2:0] error_code;
  } out_item_t;

  function automatic field_t next_field(input logic [1:0] kind, input field_t f);
    field_t nf;
    nf = FLD_END;
    case (kind)
      KIND_CLIENT_HELLO: begin
        case (f)
          FLD_TYPE: nf = FLD_IDLEN;
          FLD_ID: nf = FLD_PUBKEY;
          FLD_PUBKEY: nf = FLD_SESSION;
          FLD_SESSION: nf = FLD_NONCE;
          default: nf = FLD_END;
        endcase
      end
      KIND_SERVER_HELLO: begin
        case (f)
          FLD_TYPE: nf = FLD_IDLEN;
          FLD_ID: nf = FLD_PUBKEY;
          FLD_PUBKEY: nf = FLD_NONCE;
          FLD_NONCE: nf = FLD_SESSION;
          FLD_SESSION: nf = FLD_SIGLEN;
          default: nf = FLD_END;
        endcase
      end
      KIND_CLIENT_AUTH: begin
        case (f)
          FLD_TYPE: nf = FLD_HSID;
          FLD_HSID: nf = FLD_SIGLEN;
          default: nf = FLD_END;
        endcase
      end
      default: nf = FLD_END;
    endcase
    return nf;
  endfunction

endpackage

@@ rtl/hmd_cfg.sv @@
module hmd_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [hmd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hmd_pkg::CFG_DATA_W-1:0] cfg_data,
  output hmd_pkg::cfg_t cfg
);
  import hmd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.id_min_length <= RST_ID_MIN;
      cfg.id_max_length <= RST_ID_MAX;
      cfg.sig_max_length <= RST_SIG_MAX;
      cfg.code_client_hello <= RST_CODE_CH;
      cfg.code_server_hello <= RST_CODE_SH;
      cfg.code_client_auth <= RST_CODE_CA;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ID_MIN: cfg.id_min_length <= cfg_data[7:0];
        CFG_ID_MAX: cfg.id_max_length <= cfg_data[7:0];
        CFG_SIG_MAX: cfg.sig_max_length <= cfg_data;
        CFG_CODE_CH: cfg.code_client_hello <= cfg_data[7:0];
        CFG_CODE_SH: cfg.code_server_hello <= cfg_data[7:0];
        CFG_CODE_CA: cfg.code_client_auth <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/hmd_parse.sv @@
module hmd_parse #(
  parameter int PUBKEY_BYTES = 32,
  parameter int SESSION_BYTES = 16,
  parameter int NONCE_BYTES = 32,
  parameter int HANDSHAKE_ID_BYTES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  hmd_pkg::in_item_t item,
  input  hmd_pkg::cfg_t cfg,
  output hmd_pkg::out_item_t result
);
  import hmd_pkg::*;

  logic [POS_W-1:0] position;
  field_t cur;
  logic [REM_W-1:0] remaining;
  logic [1:0] held_kind;
  logic [7:0] sig_high;
  err_t first_error;

  logic [POS_W-1:0] position_next;
  field_t cur_next;
  logic [REM_W-1:0] remaining_next;
  logic [1:0] held_kind_next;
  logic [7:0] sig_high_next;
  err_t first_error_next;

  logic start;
  logic [1:0] kind_eff;
  field_t cur_eff;
  logic [REM_W-1:0] rem_eff;
  err_t err_eff;

  field_t cur_upd;
  logic [REM_W-1:0] rem_upd;
  err_t err_upd;
  err_t err_fin;
  logic do_fault;
  err_t fault_code;
  logic do_enter;
  field_t enter_fld;
  logic type_ok;
  logic [REM_W-1:0] sig_len;
  logic [REM_W-1:0] rem_dec;

  function automatic logic [REM_W-1:0] field_len(input field_t f);
    logic [REM_W-1:0] n;
    case (f)
      FLD_IDLEN: n = REM_W'(1);
      FLD_PUBKEY: n = REM_W'(PUBKEY_BYTES);
      FLD_SESSION: n = REM_W'(SESSION_BYTES);
      FLD_NONCE: n = REM_W'(NONCE_BYTES);
      FLD_HSID: n = REM_W'(HANDSHAKE_ID_BYTES);
      FLD_SIGLEN: n = REM_W'(2);
      default: n = '0;
    endcase
    return n;
  endfunction

  assign start = (position == '0);
  assign kind_eff = start ? item.expected_kind : held_kind;
  assign cur_eff = start ? FLD_TYPE : cur;
  assign rem_eff = start ? REM_W'(1) : remaining;
  assign err_eff = start ? ERR_NONE : first_error;

  always_comb begin
    do_fault = 1'b0;
    fault_code = ERR_NONE;
    do_enter = 1'b0;
    enter_fld = FLD_END;
    cur_upd = cur_eff;
    rem_upd = rem_eff;
    err_upd = err_eff;
    sig_high_next = sig_high;
    type_ok = 1'b0;
    sig_len = {sig_high, item.data_byte};
    rem_dec = (rem_eff != '0) ? rem_eff - REM_W'(1) : '0;

    case (cur_eff)
      FLD_TYPE: begin
        type_ok = (kind_eff == KIND_CLIENT_HELLO && item.data_byte == cfg.code_client_hello) ||
                  (kind_eff == KIND_SERVER_HELLO && item.data_byte == cfg.code_server_hello) ||
                  (kind_eff == KIND_CLIENT_AUTH && item.data_byte == cfg.code_client_auth);
        if (!type_ok) begin
          do_fault = 1'b1;
          fault_code = ERR_TYPE;
        end else begin
          do_enter = 1'b1;
          enter_fld = next_field(kind_eff, FLD_TYPE);
        end
      end
      FLD_IDLEN: begin
        if (item.data_byte < cfg.id_min_length || item.data_byte > cfg.id_max_length) begin
          do_fault = 1'b1;
          fault_code = ERR_ID_LEN;
        end else if (item.data_byte == 8'd0) begin
          do_enter = 1'b1;
          enter_fld = next_field(kind_eff, FLD_ID);
        end else begin
          cur_upd = FLD_ID;
          rem_upd = {8'd0, item.data_byte};
        end
      end
      FLD_SIGLEN: begin
        if (rem_eff >= REM_W'(2)) begin
          sig_high_next = item.data_byte;
          rem_upd = REM_W'(1);
        end else if (sig_len == '0 || sig_len > cfg.sig_max_length) begin
          do_fault = 1'b1;
          fault_code = ERR_SIG_LEN;
        end else begin
          cur_upd = FLD_SIG;
          rem_upd = sig_len;
        end
      end
      FLD_ID, FLD_PUBKEY, FLD_SESSION, FLD_NONCE, FLD_HSID, FLD_SIG: begin
        rem_upd = rem_dec;
        if (rem_dec == '0) begin
          do_enter = 1'b1;
          enter_fld = next_field(kind_eff, cur_eff);
        end
      end
      default: begin
        do_fault = 1'b1;
        fault_code = ERR_TRAILING;
      end
    endcase

    if (do_fault) begin
      cur_upd = FLD_END;
      rem_upd = '0;
      if (err_eff == ERR_NONE) begin
        err_upd = fault_code;
      end
    end else if (do_enter) begin
      cur_upd = enter_fld;
      rem_upd = field_len(enter_fld);
    end

    err_fin = err_upd;
    if (cur_upd != FLD_END && err_upd == ERR_NONE) begin
      err_fin = ERR_SHORT;
    end

    if (item.last_byte) begin
      position_next = '0;
      cur_next = FLD_TYPE;
      remaining_next = '0;
      held_kind_next = KIND_CLIENT_HELLO;
      first_error_next = ERR_NONE;
    end else begin
      position_next = (position < POS_MAX) ? position + POS_W'(1) : position;
      cur_next = cur_upd;
      remaining_next = rem_upd;
      held_kind_next = kind_eff;
      first_error_next = err_upd;
    end
  end

  always_comb begin
    result.byte_out = item.data_byte;
    result.field_code = (cur_eff == FLD_END) ? FLD_SIG : cur_eff;
    result.byte_offset = position;
    result.msg_done = item.last_byte;
    result.msg_valid = item.last_byte && (err_fin == ERR_NONE);
    result.error_code = item.last_byte ? err_fin : ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      cur <= FLD_TYPE;
      remaining <= '0;
      held_kind <= KIND_CLIENT_HELLO;
      sig_high <= '0;
      first_error <= ERR_NONE;
    end else if (step) begin
      position <= position_next;
      cur <= cur_next;
      remaining <= remaining_next;
      held_kind <= held_kind_next;
      sig_high <= sig_high_next;
      first_error <= first_error_next;
    end
  end

endmodule

@@ rtl/handshake_message_deframer.sv @@
// Handshake message deframer: one byte item is accepted per clock cycle while
// byte_stall is low, and every byte yields exactly one result item through the
// input register and the result register, tagged with its field and offset; the
// item that carries the last-byte mark also carries the verdict. The rate is set
// by the combinational field tracker between the two registers; a stalled result
// holds the input register, so stall on the result side reaches the byte side in
// the same cycle. The user must write configuration through the plain write port
// while no message bytes are in flight; the block itself does not enforce this.
module handshake_message_deframer #(
  parameter int PUBKEY_BYTES = 32,
  parameter int SESSION_BYTES = 16,
  parameter int NONCE_BYTES = 32,
  parameter int HANDSHAKE_ID_BYTES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic byte_valid,
  output logic byte_stall,
  input  hmd_pkg::in_item_t byte_item,
  output logic result_valid,
  input  logic result_stall,
  output hmd_pkg::out_item_t result_item,
  input  logic cfg_write,
  input  logic [hmd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hmd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hmd_pkg::*;

  cfg_t cfg;
  logic s1_valid;
  in_item_t s1_item;
  logic s1_move;
  out_item_t parsed;

  assign s1_move = s1_valid && (!result_valid || !result_stall);
  assign byte_stall = s1_valid && !s1_move;

  hmd_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  hmd_parse #(
    .PUBKEY_BYTES(PUBKEY_BYTES),
    .SESSION_BYTES(SESSION_BYTES),
    .NONCE_BYTES(NONCE_BYTES),
    .HANDSHAKE_ID_BYTES(HANDSHAKE_ID_BYTES)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .step(s1_move),
    .item(s1_item),
    .cfg(cfg),
    .result(parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_item <= byte_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result_item <= parsed;
    end
  end

endmodule

@@ test/handshake_message_deframer_tb.sv @@
module handshake_message_deframer_tb;
  import hmd_pkg::*;

  localparam int PUBKEY_LEN = 32;
  localparam int SESSION_LEN = 16;
  localparam int NONCE_LEN = 32;
  localparam int HSID_LEN = 16;
  localparam logic [1:0] KIND_UNDEFINED = 2'd3;

  typedef struct packed {
    in_item_t stim;
    out_item_t want;
  } row_t;

  logic clk;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  in_item_t byte_item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_item_t result_item;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  handshake_message_deframer #(
    .PUBKEY_BYTES(PUBKEY_LEN),
    .SESSION_BYTES(SESSION_LEN),
    .NONCE_BYTES(NONCE_LEN),
    .HANDSHAKE_ID_BYTES(HSID_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item(byte_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item(result_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cfg_t cfg_model = '{RST_ID_MIN, RST_ID_MAX, RST_SIG_MAX, RST_CODE_CH, RST_CODE_SH,
                      RST_CODE_CA};
  logic [POS_W-1:0] msg_pos = '0;
  field_t frame_field = FLD_TYPE;
  logic [REM_W-1:0] field_left = '0;
  logic [1:0] kind_held = '0;
  logic [7:0] sig_len_high = '0;
  err_t fault_latched = ERR_NONE;

  out_item_t expected_results [$];
  row_t directed_rows [$];
  logic [7:0] msg_bytes [$];
  logic typed_row = 1'b0;
  out_item_t typed_want = '0;
  logic no_idling = 1'b0;
  int unsigned mismatches = 0;
  int unsigned phase_items = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic flag_error(string msg);
    if (mismatches < 40) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic field_t following_field(field_t f);
    case (f)
      FLD_TYPE: begin
        if (kind_held == KIND_CLIENT_AUTH) return FLD_HSID;
        if (kind_held == KIND_UNDEFINED) return FLD_END;
        return FLD_IDLEN;
      end
      FLD_ID: return (kind_held == KIND_CLIENT_AUTH || kind_held == KIND_UNDEFINED) ?
                     FLD_END : FLD_PUBKEY;
      FLD_PUBKEY: begin
        if (kind_held == KIND_CLIENT_HELLO) return FLD_SESSION;
        if (kind_held == KIND_SERVER_HELLO) return FLD_NONCE;
        return FLD_END;
      end
      FLD_SESSION: begin
        if (kind_held == KIND_CLIENT_HELLO) return FLD_NONCE;
        if (kind_held == KIND_SERVER_HELLO) return FLD_SIGLEN;
        return FLD_END;
      end
      FLD_NONCE: return (kind_held == KIND_SERVER_HELLO) ? FLD_SESSION : FLD_END;
      FLD_HSID: return (kind_held == KIND_CLIENT_AUTH) ? FLD_SIGLEN : FLD_END;
      default: return FLD_END;
    endcase
  endfunction

  function automatic void begin_field(field_t f);
    frame_field = f;
    case (f)
      FLD_IDLEN: field_left = REM_W'(1);
      FLD_PUBKEY: field_left = REM_W'(PUBKEY_LEN);
      FLD_SESSION: field_left = REM_W'(SESSION_LEN);
      FLD_NONCE: field_left = REM_W'(NONCE_LEN);
      FLD_HSID: field_left = REM_W'(HSID_LEN);
      FLD_SIGLEN: field_left = REM_W'(2);
      default: field_left = '0;
    endcase
  endfunction

  function automatic void latch_fault(err_t code);
    if (fault_latched == ERR_NONE) fault_latched = code;
    frame_field = FLD_END;
    field_left = '0;
  endfunction

  function automatic out_item_t deframe_byte(in_item_t it);
    out_item_t r;
    logic [15:0] sig_len;
    logic type_ok;
    logic [7:0] b;
    b = it.data_byte;
    if (msg_pos == 0) begin
      kind_held = it.expected_kind;
      frame_field = FLD_TYPE;
      field_left = REM_W'(1);
      fault_latched = ERR_NONE;
    end
    r.byte_out = b;
    r.field_code = (frame_field == FLD_END) ? FLD_SIG : frame_field;
    r.byte_offset = msg_pos;
    case (frame_field)
      FLD_TYPE: begin
        type_ok = (kind_held == KIND_CLIENT_HELLO && b == cfg_model.code_client_hello) ||
                  (kind_held == KIND_SERVER_HELLO && b == cfg_model.code_server_hello) ||
                  (kind_held == KIND_CLIENT_AUTH && b == cfg_model.code_client_auth);
        if (!type_ok) latch_fault(ERR_TYPE);
        else begin_field(following_field(FLD_TYPE));
      end
      FLD_IDLEN: begin
        if (b < cfg_model.id_min_length || b > cfg_model.id_max_length) begin
          latch_fault(ERR_ID_LEN);
        end else if (b == 0) begin
          begin_field(following_field(FLD_ID));
        end else begin
          frame_field = FLD_ID;
          field_left = {8'd0, b};
        end
      end
      FLD_SIGLEN: begin
        if (field_left >= 2) begin
          sig_len_high = b;
          field_left = REM_W'(1);
        end else begin
          sig_len = {sig_len_high, b};
          if (sig_len == 0 || sig_len > cfg_model.sig_max_length) begin
            latch_fault(ERR_SIG_LEN);
          end else begin
            frame_field = FLD_SIG;
            field_left = sig_len;
          end
        end
      end
      FLD_END: latch_fault(ERR_TRAILING);
      default: begin
        if (field_left != 0) field_left = field_left - 1'b1;
        if (field_left == 0) begin_field(following_field(frame_field));
      end
    endcase
    if (it.last_byte) begin
      if (frame_field != FLD_END && fault_latched == ERR_NONE) fault_latched = ERR_SHORT;
      r.msg_done = 1'b1;
      r.msg_valid = (fault_latched == ERR_NONE);
      r.error_code = fault_latched;
      msg_pos = '0;
      frame_field = FLD_TYPE;
      field_left = '0;
      kind_held = '0;
      sig_len_high = '0;
      fault_latched = ERR_NONE;
    end else begin
      r.msg_done = 1'b0;
      r.msg_valid = 1'b0;
      r.error_code = ERR_NONE;
      if (msg_pos != POS_MAX) msg_pos = msg_pos + 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    out_item_t want;
    if (!rst) begin
      if (byte_valid && !byte_stall) begin
        want = deframe_byte(byte_item);
        if (typed_row) want = typed_want;
        expected_results.push_back(want);
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result item at offset %0d with none expected",
                               result_item.byte_offset));
        end else begin
          want = expected_results.pop_front();
          if (result_item.byte_out !== want.byte_out)
            flag_error($sformatf("byte_out %0h, expected %0h at offset %0d",
                                 result_item.byte_out, want.byte_out, want.byte_offset));
          if (result_item.field_code !== want.field_code)
            flag_error($sformatf("field_code %0d, expected %0d at offset %0d",
                                 result_item.field_code, want.field_code, want.byte_offset));
          if (result_item.byte_offset !== want.byte_offset)
            flag_error($sformatf("byte_offset %0d, expected %0d",
                                 result_item.byte_offset, want.byte_offset));
          if (result_item.msg_done !== want.msg_done)
            flag_error($sformatf("msg_done %0b, expected %0b at offset %0d",
                                 result_item.msg_done, want.msg_done, want.byte_offset));
          if (result_item.msg_valid !== want.msg_valid)
            flag_error($sformatf("msg_valid %0b, expected %0b at offset %0d",
                                 result_item.msg_valid, want.msg_valid, want.byte_offset));
          if (result_item.error_code !== want.error_code)
            flag_error($sformatf("error_code %0d, expected %0d at offset %0d",
                                 result_item.error_code, want.error_code, want.byte_offset));
        end
      end
    end
  end

  always @(negedge clk) begin
    result_stall <= !no_idling && ($urandom_range(99) < 14);
  end

  task automatic send_byte(in_item_t it);
    while (!no_idling && $urandom_range(99) < 14) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_queued(logic [1:0] kind);
    in_item_t it;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      it.data_byte = msg_bytes[i];
      it.last_byte = (i == msg_bytes.size() - 1);
      it.expected_kind = (i == 0) ? kind : 2'($urandom_range(3));
      send_byte(it);
    end
    phase_items += msg_bytes.size();
  endtask

  task automatic add_random(int unsigned n);
    repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic drain(int unsigned pause);
    byte_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (pause) @(negedge clk);
  endtask

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  task automatic load_config(cfg_t c);
    drain(4);
    put_reg(CFG_ID_MIN, CFG_DATA_W'(c.id_min_length));
    put_reg(CFG_ID_MAX, CFG_DATA_W'(c.id_max_length));
    put_reg(CFG_SIG_MAX, c.sig_max_length);
    put_reg(CFG_CODE_CH, CFG_DATA_W'(c.code_client_hello));
    put_reg(CFG_CODE_SH, CFG_DATA_W'(c.code_server_hello));
    put_reg(CFG_CODE_CA, CFG_DATA_W'(c.code_client_auth));
    cfg_write <= 1'b0;
    cfg_model = c;
  endtask

  // Most messages are well formed with random content; the rest carry one kind
  // of damage each: wrong type, bad lengths, a cut, extra bytes, or pure noise.
  task automatic send_message();
    logic [1:0] kind;
    logic [15:0] sig_len;
    int unsigned shape, id_len, span, smax, cut;
    shape = $urandom_range(99);
    kind = (shape < 4) ? KIND_UNDEFINED : 2'($urandom_range(2));
    msg_bytes.delete();
    case (kind)
      KIND_CLIENT_HELLO: msg_bytes.push_back(cfg_model.code_client_hello);
      KIND_SERVER_HELLO: msg_bytes.push_back(cfg_model.code_server_hello);
      KIND_CLIENT_AUTH: msg_bytes.push_back(cfg_model.code_client_auth);
      default: msg_bytes.push_back(8'($urandom_range(255)));
    endcase
    if (shape >= 4 && shape < 10) msg_bytes[0] = 8'($urandom_range(255));
    if (kind == KIND_CLIENT_AUTH) begin
      add_random(HSID_LEN);
    end else begin
      if (cfg_model.id_min_length > cfg_model.id_max_length || (shape >= 10 && shape < 16)) begin
        id_len = $urandom_range(255);
      end else begin
        span = cfg_model.id_max_length - cfg_model.id_min_length;
        id_len = cfg_model.id_min_length +
                 (($urandom_range(9) == 0) ? span : $urandom_range(span < 6 ? span : 6));
      end
      msg_bytes.push_back(8'(id_len));
      add_random(id_len);
      add_random(PUBKEY_LEN);
      if (kind == KIND_SERVER_HELLO) begin
        add_random(NONCE_LEN);
        add_random(SESSION_LEN);
      end else begin
        add_random(SESSION_LEN);
        add_random(NONCE_LEN);
      end
    end
    if (kind == KIND_SERVER_HELLO || kind == KIND_CLIENT_AUTH) begin
      smax = cfg_model.sig_max_length;
      if (shape >= 16 && shape < 24) begin
        case ($urandom_range(2))
          0: sig_len = 16'd0;
          1: sig_len = cfg_model.sig_max_length + 16'd1;
          default: sig_len = 16'($urandom_range(65535));
        endcase
      end else if ($urandom_range(15) == 0) begin
        sig_len = $urandom_range(1) ? 16'(smax < 400 ? smax : 400) :
                  16'(1 + $urandom_range(smax - 1 < 399 ? smax - 1 : 399));
      end else begin
        sig_len = 16'(1 + $urandom_range(smax - 1 < 6 ? smax - 1 : 6));
      end
      msg_bytes.push_back(sig_len[15:8]);
      msg_bytes.push_back(sig_len[7:0]);
      add_random(sig_len > 420 ? 420 : sig_len);
    end
    if (shape >= 24 && shape < 34) begin
      cut = 1 + $urandom_range(msg_bytes.size() - 2);
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end else if (shape >= 34 && shape < 42) begin
      add_random(1 + $urandom_range(2));
    end else if (shape >= 42 && shape < 48) begin
      msg_bytes.delete();
      add_random(1 + $urandom_range(11));
    end
    send_queued(kind);
  endtask

  function automatic row_t directed_row(logic [7:0] b, logic last, logic [1:0] kind,
                                        field_t fld, int unsigned off, err_t err);
    row_t r;
    r.stim.data_byte = b;
    r.stim.last_byte = last;
    r.stim.expected_kind = kind;
    r.want.byte_out = b;
    r.want.field_code = fld;
    r.want.byte_offset = POS_W'(off);
    r.want.msg_done = last;
    r.want.msg_valid = last && (err == ERR_NONE);
    r.want.error_code = err;
    return r;
  endfunction

  initial begin : stimulus
    cfg_t next_cfg;
    directed_rows.push_back(directed_row(8'h01, 1'b1, KIND_CLIENT_HELLO, FLD_TYPE, 0, ERR_SHORT));
    directed_rows.push_back(directed_row(8'h02, 1'b1, KIND_CLIENT_HELLO, FLD_TYPE, 0, ERR_TYPE));
    directed_rows.push_back(directed_row(8'hFF, 1'b1, KIND_UNDEFINED, FLD_TYPE, 0, ERR_TYPE));
    directed_rows.push_back(directed_row(8'h00, 1'b1, KIND_SERVER_HELLO, FLD_TYPE, 0, ERR_TYPE));
    directed_rows.push_back(directed_row(8'h01, 1'b0, KIND_CLIENT_HELLO, FLD_TYPE, 0, ERR_NONE));
    directed_rows.push_back(directed_row(8'h00, 1'b0, KIND_CLIENT_HELLO, FLD_IDLEN, 1, ERR_NONE));
    directed_rows.push_back(directed_row(8'hAA, 1'b1, KIND_CLIENT_HELLO, FLD_SIG, 2, ERR_ID_LEN));
    directed_rows.push_back(directed_row(8'h02, 1'b0, KIND_SERVER_HELLO, FLD_TYPE, 0, ERR_NONE));
    directed_rows.push_back(directed_row(8'd65, 1'b1, KIND_SERVER_HELLO, FLD_IDLEN, 1, ERR_ID_LEN));
    directed_rows.push_back(directed_row(8'h03, 1'b0, KIND_CLIENT_AUTH, FLD_TYPE, 0, ERR_NONE));
    directed_rows.push_back(directed_row(8'h00, 1'b1, KIND_CLIENT_AUTH, FLD_HSID, 1, ERR_SHORT));
    directed_rows.push_back(directed_row(8'h01, 1'b0, KIND_CLIENT_HELLO, FLD_TYPE, 0, ERR_NONE));
    directed_rows.push_back(directed_row(8'd64, 1'b1, KIND_CLIENT_HELLO, FLD_IDLEN, 1, ERR_SHORT));
    directed_rows.push_back(directed_row(8'hFF, 1'b0, KIND_CLIENT_AUTH, FLD_TYPE, 0, ERR_NONE));
    directed_rows.push_back(directed_row(8'h00, 1'b1, KIND_CLIENT_AUTH, FLD_SIG, 1, ERR_TYPE));
    directed_rows.push_back(directed_row(8'h02, 1'b0, KIND_SERVER_HELLO, FLD_TYPE, 0, ERR_NONE));
    directed_rows.push_back(directed_row(8'h01, 1'b0, KIND_SERVER_HELLO, FLD_IDLEN, 1, ERR_NONE));
    directed_rows.push_back(directed_row(8'h55, 1'b1, KIND_SERVER_HELLO, FLD_ID, 2, ERR_SHORT));

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      typed_row <= 1'b1;
      typed_want <= directed_rows[i].want;
      send_byte(directed_rows[i].stim);
    end
    typed_row <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: next_cfg = '{8'd0, 8'd255, 16'd1, 8'd0, 8'd255, 8'd128};
        2: next_cfg = '{8'd255, 8'd255, 16'd2, 8'hA5, 8'hA5, 8'h5A};
        3: next_cfg = '{8'd3, 8'd5, 16'd65535, 8'd255, 8'd0, 8'd7};
        4: next_cfg = '{8'd0, 8'd0, 16'd20, 8'd9, 8'd10, 8'd11};
        default: begin
          next_cfg.id_min_length = 8'($urandom_range(255));
          next_cfg.id_max_length = 8'($urandom_range(255));
          next_cfg.sig_max_length = 16'(1 + $urandom_range(65534));
          next_cfg.code_client_hello = 8'($urandom_range(255));
          next_cfg.code_server_hello = 8'($urandom_range(255));
          next_cfg.code_client_auth = 8'($urandom_range(255));
        end
      endcase
      if (phase != 0) load_config(next_cfg);
      // The last phase runs with both sides busy on every cycle.
      no_idling = (phase == 5);
      phase_items = 0;
      while (phase_items < 250) send_message();
    end
    no_idling = 1'b0;

    drain(10);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
